@@ src/lt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line tokenizer package
// Field widths, token and error codes, scanner modes and the record types
// that travel between the scanner and the result queue.
// ----------------------------------------------------------------------------
package lt_pkg;

    localparam int CH_W    = 8;
    localparam int START_W = 12;
    localparam int LEN_W   = 13;

    // Token kinds as seen on the result channel.
    typedef enum logic [3:0] {
        K_IDENT  = 4'd0,
        K_NUMBER = 4'd1,
        K_OP     = 4'd2,
        K_EQ     = 4'd3,
        K_LPAR   = 4'd4,
        K_RPAR   = 4'd5,
        K_LBRACK = 4'd6,
        K_RBRACK = 4'd7,
        K_EOL    = 4'd8,
        K_ERROR  = 4'd9
    } t_kind;

    // Error codes carried by error tokens.
    typedef enum logic [1:0] {
        E_EXP     = 2'd0,
        E_TOUCH   = 2'd1,
        E_UNKNOWN = 2'd2
    } t_err;

    // Scanner modes. The six pending modes hold a one-character token that
    // is reported when the next character arrives.
    typedef enum logic [3:0] {
        M_START       = 4'd0,
        M_DONE        = 4'd1,
        M_EOL         = 4'd2,
        M_IDENT       = 4'd3,
        M_SIGN        = 4'd4,
        M_INT         = 4'd5,
        M_FRAC        = 4'd6,
        M_EXPMARK     = 4'd7,
        M_EXPSIGN     = 4'd8,
        M_EXPDIG      = 4'd9,
        M_PEND_OP     = 4'd10,
        M_PEND_EQ     = 4'd11,
        M_PEND_LPAR   = 4'd12,
        M_PEND_RPAR   = 4'd13,
        M_PEND_LBRACK = 4'd14,
        M_PEND_RBRACK = 4'd15
    } t_mode;

    // One result record.
    typedef struct packed {
        t_kind              kind;
        logic [START_W-1:0] start_pos;
        logic [LEN_W-1:0]   length;
        t_err               error_code;
        logic               last;
    } t_tok;

    // Up to two records pushed by the scanner for one character.
    typedef struct packed {
        logic v0;
        logic v1;
        t_tok rec0;
        t_tok rec1;
    } t_push;

endpackage

@@ src/lt_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line tokenizer channels
// Valid/ready channels for incoming characters and outgoing token records.
// ----------------------------------------------------------------------------

// Character channel: one character word per handshake.
interface lt_char_if import lt_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] ch;
    logic            first_of_line;

    modport source (output valid, output ch, output first_of_line, input ready);
    modport sink   (input valid, input ch, input first_of_line, output ready);
endinterface

// Token channel: one token record word per handshake.
interface lt_tok_if import lt_pkg::*; ();
    logic               valid;
    logic               ready;
    t_kind              kind;
    logic [START_W-1:0] start_pos;
    logic [LEN_W-1:0]   length;
    t_err               error_code;
    logic               last;

    modport source (output valid, output kind, output start_pos, output length,
                    output error_code, output last, input ready);
    modport sink   (input valid, input kind, input start_pos, input length,
                    input error_code, input last, output ready);
endinterface

@@ src/lt_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line tokenizer scanner
// Accepts one character per cycle while the result queue has room, classifies it,
// advances its mode and pushes zero, one or two token records to the queue.
// ----------------------------------------------------------------------------
module lt_front import lt_pkg::*; #(
    parameter int LINE_MAX = 4096
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    lt_char_if.sink i_char,
    input  logic   i_space,
    output t_push  o_push
);

    localparam int PW = $clog2(LINE_MAX + 1);
    localparam int TW = $clog2(LINE_MAX);
    localparam logic [PW-1:0] POS_MAX = PW'(LINE_MAX);

    t_mode          r_mode, n_mode;
    logic [TW-1:0]  r_ts, n_ts;
    logic [PW-1:0]  r_pos, n_pos;

    logic           acc;
    logic [CH_W-1:0] c;
    t_mode          mode_eff;
    logic [PW-1:0]  p;
    logic [TW-1:0]  p_t;
    logic [LEN_W-1:0] run_len;

    logic is_digit, is_alpha, is_sign, is_crlf, is_ws, is_e;
    t_mode ss_mode;
    logic  ss_fail;
    logic  do_ss;

    logic  tok_v, err_v;
    t_kind tok_kind;
    logic [LEN_W-1:0] tok_len;
    t_err  err_code;
    t_tok  tok_rec, err_rec;

    assign i_char.ready = i_space;
    assign acc = i_char.valid & i_space;
    assign c   = i_char.ch;

    // A new line puts the scanner back at position zero in start mode.
    assign mode_eff = i_char.first_of_line ? M_START : r_mode;
    assign p        = i_char.first_of_line ? '0 : r_pos;
    assign p_t      = TW'(p);
    assign run_len  = LEN_W'(p_t - r_ts);

    // Character classes, C locale ASCII.
    always_comb begin
        is_digit = c inside {[8'h30:8'h39]};
        is_alpha = c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
        is_sign  = c inside {8'h2B, 8'h2D};
        is_crlf  = c inside {8'h0A, 8'h0D};
        is_ws    = c inside {8'h09, 8'h0B, 8'h0C, 8'h20};
        is_e     = c inside {8'h45, 8'h65};
    end

    // Mode chosen when a character opens a new token.
    always_comb begin
        ss_fail = 1'b0;
        ss_mode = M_START;
        if (is_crlf) begin
            ss_mode = M_EOL;
        end else if (is_ws) begin
            ss_mode = M_START;
        end else if (is_digit) begin
            ss_mode = M_INT;
        end else if (is_sign) begin
            ss_mode = M_SIGN;
        end else if (is_alpha) begin
            ss_mode = M_IDENT;
        end else if (c == 8'h2A || c == 8'h2F) begin
            ss_mode = M_PEND_OP;
        end else if (c == 8'h3D) begin
            ss_mode = M_PEND_EQ;
        end else if (c == 8'h28) begin
            ss_mode = M_PEND_LPAR;
        end else if (c == 8'h29) begin
            ss_mode = M_PEND_RPAR;
        end else if (c == 8'h5B) begin
            ss_mode = M_PEND_LBRACK;
        end else if (c == 8'h5D) begin
            ss_mode = M_PEND_RBRACK;
        end else begin
            ss_fail = 1'b1;
        end
    end

    // Next state and the records caused by the current character.
    always_comb begin
        n_mode   = r_mode;
        n_ts     = r_ts;
        n_pos    = r_pos;
        tok_v    = 1'b0;
        tok_kind = K_IDENT;
        tok_len  = run_len;
        err_v    = 1'b0;
        err_code = E_EXP;
        do_ss    = 1'b0;
        if (acc) begin
            n_mode = mode_eff;
            if (p == POS_MAX) begin
                // Overlong line: the character is dropped.
                n_pos = POS_MAX;
            end else begin
                n_pos = p + 1'b1;
                case (mode_eff)
                    M_START: begin
                        do_ss = 1'b1;
                    end
                    M_EOL: begin
                        if (!is_crlf) begin
                            tok_v    = 1'b1;
                            tok_kind = K_EOL;
                            n_mode   = M_DONE;
                        end
                    end
                    M_IDENT: begin
                        if (!(is_alpha || is_digit)) begin
                            tok_v    = 1'b1;
                            tok_kind = K_IDENT;
                            do_ss    = 1'b1;
                        end
                    end
                    M_SIGN: begin
                        if (is_digit) begin
                            n_mode = M_INT;
                        end else begin
                            tok_v    = 1'b1;
                            tok_kind = K_OP;
                            tok_len  = LEN_W'(1);
                            do_ss    = 1'b1;
                        end
                    end
                    M_INT, M_FRAC, M_EXPDIG: begin
                        if (is_digit) begin
                            n_mode = mode_eff;
                        end else if (mode_eff == M_INT && c == 8'h2E) begin
                            n_mode = M_FRAC;
                        end else if (mode_eff != M_EXPDIG && is_e) begin
                            n_mode = M_EXPMARK;
                        end else if (is_alpha) begin
                            err_v    = 1'b1;
                            err_code = E_TOUCH;
                            n_mode   = M_DONE;
                        end else begin
                            tok_v    = 1'b1;
                            tok_kind = K_NUMBER;
                            if (is_sign) begin
                                // A sign after a number is always an operator.
                                n_ts   = p_t;
                                n_mode = M_PEND_OP;
                            end else begin
                                do_ss = 1'b1;
                            end
                        end
                    end
                    M_EXPMARK: begin
                        if (is_sign) begin
                            n_mode = M_EXPSIGN;
                        end else if (is_digit) begin
                            n_mode = M_EXPDIG;
                        end else begin
                            err_v  = 1'b1;
                            n_mode = M_DONE;
                        end
                    end
                    M_EXPSIGN: begin
                        if (is_digit) begin
                            n_mode = M_EXPDIG;
                        end else begin
                            err_v  = 1'b1;
                            n_mode = M_DONE;
                        end
                    end
                    M_DONE: begin
                        n_mode = M_DONE;
                    end
                    M_PEND_OP, M_PEND_EQ, M_PEND_LPAR, M_PEND_RPAR,
                    M_PEND_LBRACK, M_PEND_RBRACK: begin
                        tok_v   = 1'b1;
                        tok_len = LEN_W'(1);
                        do_ss   = 1'b1;
                        case (mode_eff)
                            M_PEND_EQ:     tok_kind = K_EQ;
                            M_PEND_LPAR:   tok_kind = K_LPAR;
                            M_PEND_RPAR:   tok_kind = K_RPAR;
                            M_PEND_LBRACK: tok_kind = K_LBRACK;
                            M_PEND_RBRACK: tok_kind = K_RBRACK;
                            default:       tok_kind = K_OP;
                        endcase
                    end
                    default: begin
                        n_mode = M_DONE;
                    end
                endcase

                // The current character opens a new token.
                if (do_ss) begin
                    n_ts = p_t;
                    if (ss_fail) begin
                        err_v    = 1'b1;
                        err_code = E_UNKNOWN;
                        n_mode   = M_DONE;
                    end else begin
                        n_mode = ss_mode;
                    end
                end
            end
        end
    end

    // Build the records; a token always comes before an error.
    always_comb begin
        tok_rec.kind       = tok_kind;
        tok_rec.start_pos  = START_W'(r_ts);
        tok_rec.length     = tok_len;
        tok_rec.error_code = E_EXP;
        tok_rec.last       = ~err_v;

        err_rec.kind       = K_ERROR;
        err_rec.start_pos  = START_W'(p_t);
        err_rec.length     = '0;
        err_rec.error_code = err_code;
        err_rec.last       = 1'b1;

        o_push.v0   = tok_v | err_v;
        o_push.v1   = tok_v & err_v;
        o_push.rec0 = tok_v ? tok_rec : err_rec;
        o_push.rec1 = err_rec;
    end

    // Scanner state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_START;
            r_ts   <= '0;
            r_pos  <= '0;
        end else begin
            r_mode <= n_mode;
            r_ts   <= n_ts;
            r_pos  <= n_pos;
        end
    end

`ifndef SYNTH
    a_new_line_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_char.first_of_line) |=> (r_pos == PW'(1)))
        else $error("position not restarted by a new line");
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_MAX)
        else $error("position beyond line limit");
    a_second_is_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.v1 |-> (o_push.rec1.kind == K_ERROR && o_push.rec0.kind != K_ERROR))
        else $error("second record of a character is not an error");
`endif

endmodule

@@ src/lt_res_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line tokenizer result queue
// Four-entry queue that takes up to two token records per cycle from the
// scanner and hands one record per cycle to a ready token channel.
// ----------------------------------------------------------------------------
module lt_res_queue import lt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_push    i_push,
    output logic     o_space,
    lt_tok_if.source o_tok
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    t_tok            r_mem [DEPTH];
    logic [AW-1:0]   r_wr, n_wr;
    logic [AW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_count, n_count;
    logic            pop;
    logic [1:0]      n_push;
    logic [AW-1:0]   wr_next;
    t_tok            head;

    // Room for the two records one character may cause.
    assign o_space = r_count <= CW'(DEPTH - 2);

    assign pop     = o_tok.valid & o_tok.ready;
    assign n_push  = {1'b0, i_push.v0} + {1'b0, i_push.v1};
    assign wr_next = r_wr + 1'b1;

    // Head of the queue drives the token channel.
    assign head             = r_mem[r_rd];
    assign o_tok.valid      = r_count != '0;
    assign o_tok.kind       = head.kind;
    assign o_tok.start_pos  = head.start_pos;
    assign o_tok.length     = head.length;
    assign o_tok.error_code = head.error_code;
    assign o_tok.last       = head.last;

    // Pointer and fill count updates.
    always_comb begin
        n_wr    = r_wr + AW'(n_push);
        n_rd    = r_rd + AW'(pop);
        n_count = r_count + CW'(n_push) - CW'(pop);
    end

    // Record storage.
    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wr] <= i_push.rec0;
        end
        if (i_push.v1) begin
            r_mem[wr_next] <= i_push.rec1;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

`ifndef SYNTH
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.v0 |-> (r_count <= CW'(DEPTH - 2)))
        else $error("record pushed into a full queue");
    a_push_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.v1 |-> i_push.v0)
        else $error("second record pushed without a first");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill count beyond queue depth");
    a_tok_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tok.valid && !o_tok.ready) |=> o_tok.valid)
        else $error("waiting token word withdrawn");
`endif

endmodule

@@ src/line_tokenizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line tokenizer
// Scans a text line one character word at a time and reports token records
// (identifiers, numbers, operators, brackets, end of line, errors).
//
// Usage: characters enter on i_char, one word per handshake, with
// first_of_line set on the first character of every line. Token records
// leave on o_tok as kind, start offset, length, error code and a last flag
// that marks the final record caused by one character.
// A token is reported when the character after it is taken; records caused
// by a character are written into the result queue as that character is
// accepted and reach o_tok once earlier records have left. The scanner
// takes one character per cycle while the four-entry result queue has
// room for two records; that queue space is the only limit, so characters
// that cause two records slow it while the receiver drains one per cycle.
// When o_tok stalls, records wait in the queue and i_char ready drops once
// fewer than two entries are free.
// Reset empties the queue and puts the scanner at position zero in start
// mode.
// ----------------------------------------------------------------------------
module line_tokenizer import lt_pkg::*; #(
    parameter int LINE_MAX = 4096
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    lt_char_if.sink  i_char,
    lt_tok_if.source o_tok
);

    t_push push;
    logic  space;

    // Front: character scanner.
    lt_front #(
        .LINE_MAX (LINE_MAX)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (i_char),
        .i_space (space),
        .o_push  (push)
    );

    // Back: result queue and token channel.
    lt_res_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_space (space),
        .o_tok   (o_tok)
    );

endmodule
